### design/pva_pkg.sv
`default_nettype none
package pva_pkg;

    localparam int INSTRUMENTS_DEF = 8;
    localparam int VOICES_DEF      = 8;

    localparam int PITCH_W = 24;
    localparam int BEATS_W = 24;
    localparam int TPB_W   = 24;
    localparam int TICK_W  = 32;
    localparam int INST_W  = 3;
    localparam int VOUT_W  = 3;

    localparam logic [TPB_W-1:0] TPB_RESET = 24'd12288000;

    // One voice slot as held in the slot memory.
    typedef struct packed {
        logic [PITCH_W-1:0] pitch;
        logic [TICK_W-1:0]  length;
        logic [TICK_W-1:0]  start;
    } t_slot;

    localparam int SLOT_W = $bits(t_slot);

    // Per-cycle control for the slot scanner.
    typedef struct packed {
        logic vld;    // read data of a slot is on the memory output
        logic first;  // that slot is voice 0 of the instrument
    } t_scan_ctl;

endpackage
`default_nettype wire

### design/pva_ram.sv
`default_nettype none
module pva_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             i_clk,
    input  wire logic             i_we,
    input  wire logic [AW-1:0]    i_waddr,
    input  wire logic [WIDTH-1:0] i_wdata,
    input  wire logic [AW-1:0]    i_raddr,
    output logic      [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule
`default_nettype wire

### design/pva_len.sv
`default_nettype none
module pva_len
    import pva_pkg::*;
(
    input  wire logic              i_clk,
    input  wire logic [TPB_W-1:0]  i_tpb,
    input  wire logic [BEATS_W-1:0] i_start_beats,
    input  wire logic [BEATS_W-1:0] i_length_beats,
    input  wire logic [TICK_W-1:0] i_playhead,
    output logic      [TICK_W-1:0] o_length
);

    localparam int PROD_W = BEATS_W + TPB_W;

    logic [PROD_W-1:0] w_prod_l;
    logic [PROD_W-1:0] w_prod_s;
    logic [TICK_W-1:0] r_len_ticks;
    logic [TICK_W-1:0] r_start_ticks;
    logic [TICK_W:0]   r_sum;
    logic [TICK_W+1:0] w_diff;

    // beats to ticks: (beats * tpb) >> 16
    assign w_prod_l = PROD_W'(i_length_beats) * PROD_W'(i_tpb);
    assign w_prod_s = PROD_W'(i_start_beats) * PROD_W'(i_tpb);

    // inputs are held for the whole item, so the registered products and their sum settle while it is in work
    always_ff @(posedge i_clk) begin
        r_len_ticks   <= w_prod_l[PROD_W-1:16];
        r_start_ticks <= w_prod_s[PROD_W-1:16];
        r_sum         <= (TICK_W+1)'(r_len_ticks) + (TICK_W+1)'(r_start_ticks);
    end

    assign w_diff = (TICK_W+2)'(r_sum) - (TICK_W+2)'(i_playhead);

    always_comb begin
        if (w_diff[TICK_W+1]) begin
            o_length = '0;
        end else if (w_diff[TICK_W]) begin
            o_length = '1;
        end else begin
            o_length = w_diff[TICK_W-1:0];
        end
    end

endmodule
`default_nettype wire

### design/pva_scan.sv
`default_nettype none
module pva_scan
    import pva_pkg::*;
#(
    parameter int VOICES = VOICES_DEF,
    parameter int VIDX_W = (VOICES > 1) ? $clog2(VOICES) : 1
) (
    input  wire logic               i_clk,
    input  wire t_scan_ctl          i_ctl,
    input  wire logic [VIDX_W-1:0]  i_idx,
    input  wire t_slot              i_slot,
    input  wire logic [PITCH_W-1:0] i_pitch,
    output logic      [VIDX_W-1:0]  o_best,
    output logic                    o_same
);

    logic [TICK_W:0] r_best_fin;
    logic [TICK_W:0] w_fin;
    logic            w_match;

    assign w_fin   = (TICK_W+1)'(i_slot.start) + (TICK_W+1)'(i_slot.length);
    assign w_match = (i_slot.pitch == i_pitch);

    // First pitch match wins and freezes; else earliest finish, lowest index on ties.
    always_ff @(posedge i_clk) begin
        if (i_ctl.vld) begin
            if (i_ctl.first) begin
                o_best     <= i_idx;
                o_same     <= w_match;
                r_best_fin <= w_fin;
            end else if (!o_same) begin
                if (w_match) begin
                    o_best <= i_idx;
                    o_same <= 1'b1;
                end else if (w_fin < r_best_fin) begin
                    o_best     <= i_idx;
                    r_best_fin <= w_fin;
                end
            end
        end
    end

endmodule
`default_nettype wire

### design/poly_voice_allocator.sv
// Channel   Dir  Handshake                   Payload
// item      in   start & !busy               i_mode, i_instrument, i_pitch_code,
//                                            i_start_beats, i_length_beats, i_playhead
// result    out  o_done (one-cycle strobe)   o_voice, o_same_pitch, o_voice_start,
//                                            o_voice_length
// config    in   i_cfg_valid & o_cfg_ready   i_cfg_data (ticks_per_beat)
//
// Note-on: busy while the instrument's slots are read, one slot per cycle from the
// slot memory, then a drain step and a write-back; a new item once busy drops.
// Clear: busy while every slot is zeroed, one slot per cycle, then the result.
// After reset the same clearing pass runs (busy high, no result); config writes
// are taken throughout.
// The result strobe cannot be held off; the next item may be started the cycle
// the strobe shows.
`default_nettype none
module poly_voice_allocator
    import pva_pkg::*;
#(
    parameter int INSTRUMENTS = INSTRUMENTS_DEF,
    parameter int VOICES      = VOICES_DEF
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,

    input  wire logic               start,
    output logic                    busy,
    input  wire logic               i_mode,
    input  wire logic [INST_W-1:0]  i_instrument,
    input  wire logic [PITCH_W-1:0] i_pitch_code,
    input  wire logic [BEATS_W-1:0] i_start_beats,
    input  wire logic [BEATS_W-1:0] i_length_beats,
    input  wire logic [TICK_W-1:0]  i_playhead,

    output logic                    o_done,
    output logic      [VOUT_W-1:0]  o_voice,
    output logic                    o_same_pitch,
    output logic      [TICK_W-1:0]  o_voice_start,
    output logic      [TICK_W-1:0]  o_voice_length,

    input  wire logic               i_cfg_valid,
    output logic                    o_cfg_ready,
    input  wire logic [TPB_W-1:0]   i_cfg_data
);

    localparam int SLOTS  = INSTRUMENTS * VOICES;
    localparam int ADDR_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int VIDX_W = (VOICES > 1) ? $clog2(VOICES) : 1;

    localparam logic [1:0] S_IDLE  = 2'd0;
    localparam logic [1:0] S_CLEAR = 2'd1;
    localparam logic [1:0] S_SCAN  = 2'd2;
    localparam logic [1:0] S_WRITE = 2'd3;

    // Instrument index wraps modulo INSTRUMENTS (value is under 8).
    function automatic logic [INST_W-1:0] inst_wrap(input logic [INST_W-1:0] x);
        logic [INST_W-1:0] v;
        v = x;
        for (int k = 0; k < 7; k++) begin
            if (int'(v) >= INSTRUMENTS) begin
                v = INST_W'(int'(v) - INSTRUMENTS);
            end
        end
        return v;
    endfunction

    logic [1:0]         r_state;
    logic [ADDR_W-1:0]  r_cnt;
    logic               r_clr_report;
    logic [VIDX_W-1:0]  r_vi;
    logic               r_iss;
    logic               r_rd_vld;
    logic [VIDX_W-1:0]  r_rd_idx;
    logic [TPB_W-1:0]   r_tpb;

    // item payload, held while busy
    logic [ADDR_W-1:0]  r_base;
    logic [PITCH_W-1:0] r_pitch;
    logic [BEATS_W-1:0] r_start_beats;
    logic [BEATS_W-1:0] r_length_beats;
    logic [TICK_W-1:0]  r_play;

    logic               w_accept;
    logic               w_cfg_we;
    logic               w_we;
    logic [ADDR_W-1:0]  w_waddr;
    logic [ADDR_W-1:0]  w_raddr;
    t_slot              w_wdata;
    t_slot              w_rdata;
    t_scan_ctl          w_scan_ctl;
    logic [VIDX_W-1:0]  w_best;
    logic               w_same;
    logic [TICK_W-1:0]  w_len;

    assign busy        = (r_state != S_IDLE);
    assign w_accept    = start && !busy;
    // writes are not taken while reset is held
    assign o_cfg_ready = i_rst_n;
    assign w_cfg_we    = i_cfg_valid && o_cfg_ready;

    // ---- slot memory ------------------------------------------------------
    assign w_raddr = r_base + ADDR_W'(r_vi);

    always_comb begin
        w_we    = 1'b0;
        w_waddr = r_cnt;
        w_wdata = '0;
        case (r_state)
            S_CLEAR: begin
                w_we = 1'b1;
            end
            S_WRITE: begin
                w_we           = 1'b1;
                w_waddr        = r_base + ADDR_W'(w_best);
                w_wdata.pitch  = r_pitch;
                w_wdata.length = w_len;
                w_wdata.start  = r_play;
            end
            default: begin
                w_we = 1'b0;
            end
        endcase
    end

    pva_ram #(
        .WIDTH (SLOT_W),
        .DEPTH (SLOTS),
        .AW    (ADDR_W)
    ) u_slots (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    // ---- selection over the instrument's voices --------------------------
    assign w_scan_ctl.vld   = r_rd_vld;
    assign w_scan_ctl.first = (r_rd_idx == '0);

    pva_scan #(
        .VOICES (VOICES),
        .VIDX_W (VIDX_W)
    ) u_scan (
        .i_clk   (i_clk),
        .i_ctl   (w_scan_ctl),
        .i_idx   (r_rd_idx),
        .i_slot  (w_rdata),
        .i_pitch (r_pitch),
        .o_best  (w_best),
        .o_same  (w_same)
    );

    // ---- length in ticks, lateness removed -------------------------------
    pva_len u_len (
        .i_clk          (i_clk),
        .i_tpb          (r_tpb),
        .i_start_beats  (r_start_beats),
        .i_length_beats (r_length_beats),
        .i_playhead     (r_play),
        .o_length       (w_len)
    );

    // ---- control ---------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_CLEAR;
            r_cnt        <= '0;
            r_clr_report <= 1'b0;
            r_vi         <= '0;
            r_iss        <= 1'b0;
            r_rd_vld     <= 1'b0;
            r_rd_idx     <= '0;
            r_tpb        <= TPB_RESET;
            o_done       <= 1'b0;
        end else begin
            o_done   <= 1'b0;
            r_rd_vld <= r_iss;
            r_rd_idx <= r_vi;
            if (w_cfg_we) begin
                r_tpb <= i_cfg_data;
            end
            case (r_state)
                S_IDLE: begin
                    if (w_accept) begin
                        if (i_mode) begin
                            r_state      <= S_CLEAR;
                            r_cnt        <= '0;
                            r_clr_report <= 1'b1;
                        end else begin
                            r_state <= S_SCAN;
                            r_vi    <= '0;
                            r_iss   <= 1'b1;
                        end
                    end
                end
                S_CLEAR: begin
                    r_cnt <= r_cnt + 1'b1;
                    if (r_cnt == ADDR_W'(SLOTS - 1)) begin
                        r_state      <= S_IDLE;
                        o_done       <= r_clr_report;
                        r_clr_report <= 1'b0;
                    end
                end
                S_SCAN: begin
                    if (r_iss) begin
                        if (r_vi == VIDX_W'(VOICES - 1)) begin
                            r_iss <= 1'b0;
                        end else begin
                            r_vi <= r_vi + 1'b1;
                        end
                    end
                    // last voice compared this cycle
                    if (r_rd_vld && r_rd_idx == VIDX_W'(VOICES - 1)) begin
                        r_state <= S_WRITE;
                    end
                end
                S_WRITE: begin
                    r_state <= S_IDLE;
                    r_vi    <= '0;
                    o_done  <= 1'b1;
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    // ---- payload registers -----------------------------------------------
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_base         <= ADDR_W'(int'(inst_wrap(i_instrument)) * VOICES);
            r_pitch        <= i_pitch_code;
            r_start_beats  <= i_start_beats;
            r_length_beats <= i_length_beats;
            r_play         <= i_playhead;
        end
        if (r_state == S_WRITE) begin
            o_voice        <= VOUT_W'(w_best);
            o_same_pitch   <= w_same;
            o_voice_start  <= r_play;
            o_voice_length <= w_len;
        end else if (r_state == S_CLEAR) begin
            o_voice        <= '0;
            o_same_pitch   <= 1'b0;
            o_voice_start  <= '0;
            o_voice_length <= '0;
        end
    end

    // ---- checks ----------------------------------------------------------
    a_done_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |=> !o_done)
        else $error("result strobe held for more than one cycle");

    a_done_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> !busy)
        else $error("result shown while an item is still in work");

    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |=> busy)
        else $error("accepted item did not make the block busy");

    a_scan_bounds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_WRITE) |-> (!r_iss && $past(r_rd_vld)))
        else $error("write-back before the voice scan finished");

endmodule
`default_nettype wire
